/* design/assert_macros.svh */
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CHK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/skht_pkg.sv */
// Package: sizes, codes and types of the string key hash table
package skht_pkg;

  localparam int TABLE_SLOTS   = 1024;
  localparam int MAX_KEY_BYTES = 32;
  localparam int HANDLE_BITS   = 16;

  localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
  localparam int KEY_IDX_BITS = $clog2(MAX_KEY_BYTES);
  localparam int LEN_BITS     = $clog2(MAX_KEY_BYTES + 1);
  localparam int KEY_STRIDE   = 2 ** KEY_IDX_BITS;
  localparam int KMEM_DEPTH   = TABLE_SLOTS * KEY_STRIDE;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic ACT_REGISTER = 1'b0;
  localparam logic ACT_LOOKUP   = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_OVERRIDDEN = 3'd1,
    ST_FOUND      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FULL       = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_t;

  typedef struct packed {
    logic                   valid;
    logic [LEN_BITS-1:0]    len;
    logic [HANDLE_BITS-1:0] handle;
  } meta_t;

endpackage

/* design/string_key_hash_table.sv */
// Top level: FNV-1a hash table with linear probing over string keys
// Key bytes are taken one per cycle while no key end is in progress. On the
// byte marked last the block walks the table from the home slot, unless the
// key is over MAX_KEY_BYTES long: each probed slot is first read from the
// slot memory and then checked, a slot whose stored length equals the key
// is compared byte by byte (key byte memory read, then compare), inserting a
// new key copies its bytes into the key byte memory, and last the result is
// handed to the output register. After reset the block clears all TABLE_SLOTS
// (1024) slots of the slot memory before it takes the first byte.
module string_key_hash_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [7:0]                       key_byte,
  input  logic                             key_last,
  input  logic [skht_pkg::HANDLE_BITS-1:0] handle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output skht_pkg::status_t                status,
  output logic [skht_pkg::HANDLE_BITS-1:0] found_handle,
  output logic [skht_pkg::SLOT_BITS-1:0]   slot
);
  import skht_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_PROBE   = 8'b0000_0100,
    S_CHECK   = 8'b0000_1000,
    S_CMP_RD  = 8'b0001_0000,
    S_CMP_CHK = 8'b0010_0000,
    S_COPY    = 8'b0100_0000,
    S_FINISH  = 8'b1000_0000
  } state_t;

  state_t state;

  meta_t meta_mem [TABLE_SLOTS];
  meta_t meta_q;
  meta_t meta_wdata;
  logic  meta_we;

  logic [7:0] kmem [KMEM_DEPTH];
  logic [7:0] kmem_q;
  logic [SLOT_BITS+KEY_IDX_BITS-1:0] kaddr;

  logic [7:0]             key_buffer [MAX_KEY_BYTES];
  logic [LEN_BITS-1:0]    key_length;
  logic                   key_overflow;
  logic [31:0]            running_hash;
  logic [31:0]            hash_next;
  logic [LEN_BITS-1:0]    len_next;
  logic                   ovf_next;
  logic                   len_room;

  logic [SLOT_BITS-1:0]    cur;
  logic [SLOT_BITS-1:0]    probes;
  logic [KEY_IDX_BITS-1:0] cidx;
  logic                    act;
  logic [HANDLE_BITS-1:0]  hnd;
  logic                    cidx_last;
  logic                    probes_done;

  status_t                res_status;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [SLOT_BITS-1:0]   res_slot;

  assign in_ready    = (state == S_IDLE);
  assign len_room    = (key_length < LEN_BITS'(MAX_KEY_BYTES));
  assign hash_next   = (running_hash ^ {24'd0, key_byte}) * FNV_PRIME;
  assign len_next    = len_room ? key_length + 1'b1 : key_length;
  assign ovf_next    = key_overflow | ~len_room;
  assign cidx_last   = (LEN_BITS'(cidx) == key_length - 1'b1);
  assign probes_done = (probes == SLOT_BITS'(TABLE_SLOTS - 1));
  assign kaddr       = {cur, cidx};

  always_comb begin
    meta_we    = 1'b0;
    meta_wdata = '{valid: 1'b1, len: key_length, handle: hnd};
    unique case (state)
      S_CLEAR: begin
        meta_we          = 1'b1;
        meta_wdata.valid = 1'b0;
      end
      S_CHECK:   meta_we = !meta_q.valid && (act == ACT_REGISTER);
      S_CMP_CHK: meta_we = (kmem_q == key_buffer[cidx]) && cidx_last && (act == ACT_REGISTER);
      default:   meta_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[cur] <= meta_wdata;
    end
    meta_q <= meta_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (state == S_COPY) begin
      kmem[kaddr] <= key_buffer[cidx];
    end
    kmem_q <= kmem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && len_room) begin
      key_buffer[key_length[KEY_IDX_BITS-1:0]] <= key_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cur          <= '0;
      key_length   <= '0;
      key_overflow <= 1'b0;
      running_hash <= FNV_BASIS;
      out_valid    <= 1'b0;
    end else begin
      if (out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cur <= cur + 1'b1;
          if (cur == SLOT_BITS'(TABLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            key_length   <= len_next;
            key_overflow <= ovf_next;
            if (key_last) begin
              act          <= action;
              hnd          <= handle;
              probes       <= '0;
              running_hash <= FNV_BASIS;
              if (ovf_next) begin
                res_status <= ST_TOO_LONG;
                res_handle <= '0;
                res_slot   <= '0;
                state      <= S_FINISH;
              end else begin
                cur   <= hash_next[SLOT_BITS-1:0];
                state <= S_PROBE;
              end
            end else begin
              running_hash <= hash_next;
            end
          end
        end
        S_PROBE: state <= S_CHECK;
        S_CHECK: begin
          if (!meta_q.valid) begin
            res_handle <= '0;
            if (act == ACT_REGISTER) begin
              res_status <= ST_INSERTED;
              res_slot   <= cur;
              cidx       <= '0;
              state      <= S_COPY;
            end else begin
              res_status <= ST_NOT_FOUND;
              res_slot   <= '0;
              state      <= S_FINISH;
            end
          end else if (meta_q.len == key_length) begin
            cidx  <= '0;
            state <= S_CMP_RD;
          end else if (probes_done) begin
            res_status <= (act == ACT_REGISTER) ? ST_FULL : ST_NOT_FOUND;
            res_handle <= '0;
            res_slot   <= '0;
            state      <= S_FINISH;
          end else begin
            cur    <= cur + 1'b1;
            probes <= probes + 1'b1;
            state  <= S_PROBE;
          end
        end
        S_CMP_RD: state <= S_CMP_CHK;
        S_CMP_CHK: begin
          if (kmem_q != key_buffer[cidx]) begin
            if (probes_done) begin
              res_status <= (act == ACT_REGISTER) ? ST_FULL : ST_NOT_FOUND;
              res_handle <= '0;
              res_slot   <= '0;
              state      <= S_FINISH;
            end else begin
              cur    <= cur + 1'b1;
              probes <= probes + 1'b1;
              state  <= S_PROBE;
            end
          end else if (cidx_last) begin
            res_slot <= cur;
            if (act == ACT_REGISTER) begin
              res_status <= ST_OVERRIDDEN;
              res_handle <= hnd;
            end else begin
              res_status <= ST_FOUND;
              res_handle <= meta_q.handle;
            end
            state <= S_FINISH;
          end else begin
            cidx  <= cidx + 1'b1;
            state <= S_CMP_RD;
          end
        end
        S_COPY: begin
          cidx <= cidx + 1'b1;
          if (cidx_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            status       <= res_status;
            found_handle <= res_handle;
            slot         <= res_slot;
            out_valid    <= 1'b1;
            key_length   <= '0;
            key_overflow <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/skht_chk.sv */
// Port-level checker for the string key hash table, with its bind
`include "assert_macros.svh"

module skht_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input skht_pkg::status_t                status,
  input logic [skht_pkg::HANDLE_BITS-1:0] found_handle,
  input logic [skht_pkg::SLOT_BITS-1:0]   slot
);
  import skht_pkg::*;

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot), "stalled result transaction changed")
  `CHK_NOW(a_status_range, out_valid, status <= ST_TOO_LONG, "status code out of range")
  `CHK_NOW(a_miss_zero, out_valid && (status == ST_NOT_FOUND || status == ST_FULL || status == ST_TOO_LONG), found_handle == '0 && slot == '0, "miss result not zeroed")
  `CHK_NOW(a_insert_zero, out_valid && status == ST_INSERTED, found_handle == '0, "insert result carries a handle")

endmodule

bind string_key_hash_table skht_chk u_skht_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .found_handle(found_handle), .slot(slot)
);
